// File: design/spip_pkg.sv
// Shared types, constants and tables for the spherical point-in-polygon block.
`default_nettype none
package spip_pkg;

   localparam int COORD_BITS       = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CNT_W            = 6;
   localparam int SUM_W            = 2 * COORD_BITS;
   localparam int ROOT_W           = COORD_BITS;
   localparam int REM_W            = COORD_BITS + 2;
   localparam int QUO_W            = 16;
   localparam int UNIT_W           = 17;
   localparam int PROJ_W           = 20;
   localparam int CROSS_W          = 40;
   localparam int MUL_A_W          = 40;
   localparam int MUL_B_W          = (COORD_BITS + 1 > 21) ? COORD_BITS + 1 : 21;
   localparam int WIDE_W           = 64;
   localparam int ANG_W            = 32;
   localparam int SQ_LAST          = 3;
   localparam int DIV_LAST         = 3 * QUO_W - 1;
   localparam int CROSS_LAST       = 6;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic signed [COORD_BITS-1:0] vertex_z;
      logic                         first_vertex;
      logic                         last_vertex;
   } req_type;

   typedef struct packed {
      logic                    inside_res;
      logic signed [ANG_W-1:0] winding_sum;
      logic                    too_few_vertices;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_SQ, OP_SQRT, OP_DIV, OP_SETP, OP_DOT, OP_PROJ,
      OP_TFIRST, OP_CROSS, OP_SDOT, OP_CDOT, OP_CINIT, OP_CITER, OP_ACC, OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_SQRT, S_DIV, S_SETP, S_DOT, S_PROJ, S_TFIRST,
      S_EDGE, S_CROSS, S_SDOT, S_CDOT, S_CINIT, S_CITER, S_ACC, S_EMIT
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] cnt;
      logic             src_q;    // normalize query point, not the vertex
      logic             first;    // transaction opened a polygon
      logic             close;    // closing edge: second end is first vertex
      logic             add;      // edge counts toward the sum
      logic             too_few;
   } cmd_type;

   typedef struct packed {
      logic edge_ok;
   } stat_type;

   // atan(2^-i) in binary angle units, 2^15 = pi
   function automatic logic signed [15:0] atan_entry(input logic [4:0] i);
      logic signed [15:0] t;
      case (i)
         5'd0:    t = 16'sd8192;
         5'd1:    t = 16'sd4836;
         5'd2:    t = 16'sd2555;
         5'd3:    t = 16'sd1297;
         5'd4:    t = 16'sd651;
         5'd5:    t = 16'sd326;
         5'd6:    t = 16'sd163;
         5'd7:    t = 16'sd81;
         5'd8:    t = 16'sd41;
         5'd9:    t = 16'sd20;
         5'd10:   t = 16'sd10;
         5'd11:   t = 16'sd5;
         5'd12:   t = 16'sd3;
         5'd13:   t = 16'sd1;
         5'd14:   t = 16'sd1;
         default: t = 16'sd0;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

// File: design/spherical_point_in_polygon.sv
// Top level: spherical point-in-polygon winding-angle test.
// Steps per vertex transaction: vector normalization (sum of squares, sqrt, divide),
//   projection, then one edge (cross product, dots, CORDIC; skipped when a projection
//   is zero); a first vertex first normalizes the query point; a last vertex adds the
//   closing edge, if the polygon has three or more vertices, then the result.
// One transaction at a time: a new vertex is accepted only in the idle state, after
//   the shared multiplier, bit-serial sqrt/divide and the CORDIC loop are done.
// Reset: synchronous, active high; clears control, no polygon open, no result pending.
`default_nettype none
module spherical_point_in_polygon #(
   parameter int CORDIC_STEPS = spip_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire spip_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output spip_pkg::rsp_type      rsp_data
);

   // command and status between sequencer and datapath
   spip_pkg::cmd_type  cmd;
   spip_pkg::stat_type stat;

   // controller: polygon bookkeeping, step sequencing, result handshake
   spip_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_first (req_data.first_vertex),
      .req_last  (req_data.last_vertex),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: normalization, tangent projection, angle and sum; holds the
   // result register so a new transaction can start while it waits
   spip_dp u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// File: design/spip_dp.sv
// Datapath: shared multiplier, square root, divider, projection and CORDIC.
`default_nettype none
module spip_dp (
   input  wire logic               clock,
   input  wire spip_pkg::cmd_type  cmd,
   input  wire spip_pkg::req_type  req_data,
   output spip_pkg::stat_type      stat,
   output spip_pkg::rsp_type       rsp_data
);

   localparam int C  = spip_pkg::COORD_BITS;
   localparam int W  = spip_pkg::WIDE_W;
   localparam int PW = spip_pkg::PROJ_W;
   localparam int UW = spip_pkg::UNIT_W;

   logic signed [C-1:0]  qp_ff [3];
   logic signed [C-1:0]  qp_in [3];
   logic signed [C-1:0]  vin_ff [3];
   logic signed [C-1:0]  vin_in [3];
   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] u_in [3];
   logic signed [UW-1:0] pu_ff [3];
   logic signed [UW-1:0] pu_in [3];
   logic signed [PW-1:0] tp_ff [3];
   logic signed [PW-1:0] tp_in [3];
   logic signed [PW-1:0] tf_ff [3];
   logic signed [PW-1:0] tf_in [3];
   logic signed [PW-1:0] tn_ff [3];
   logic signed [PW-1:0] tn_in [3];
   logic signed [spip_pkg::CROSS_W-1:0] c_ff [3];
   logic signed [spip_pkg::CROSS_W-1:0] c_in [3];

   logic signed [W-1:0] prod_ff, prod_in;
   logic signed [W-1:0] acc_ff, acc_in;
   logic signed [W-1:0] sin_ff, sin_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [spip_pkg::ANG_W-1:0] z_ff, z_in;
   logic signed [spip_pkg::ANG_W-1:0] sum_ff, sum_in;
   logic zflag_ff, zflag_in;
   logic [spip_pkg::SUM_W-1:0]  s_ff, s_in;
   logic [spip_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [spip_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [C:0]                  r_ff, r_in;
   logic [spip_pkg::QUO_W-1:0]  q_ff, q_in;
   spip_pkg::rsp_type           rsp_ff, rsp_in;

   logic signed [spip_pkg::MUL_A_W-1:0] mul_a;
   logic signed [spip_pkg::MUL_B_W-1:0] mul_b;
   logic signed [spip_pkg::MUL_A_W+spip_pkg::MUL_B_W-1:0] mul_p;

   logic [1:0] ai, pi, dk;
   logic [3:0] dstep;
   logic signed [C-1:0]  w_sel [3];
   logic signed [PW-1:0] tb_sel [3];
   logic signed [W-1:0]  acc_sum, proj_wide;
   logic [spip_pkg::REM_W+1:0] rem_sh, trial;
   logic [C-1:0] mag;
   logic [C:0]   r_base;
   logic         ge;
   logic [spip_pkg::QUO_W-1:0] q_new;
   logic signed [W-1:0] dx, dy;
   logic signed [spip_pkg::ANG_W-1:0] t_ang;

   function automatic logic [1:0] clip3(input logic [1:0] i);
      return (i == 2'd3) ? 2'd0 : i;
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         w_sel[k]  = cmd.src_q ? qp_ff[k] : vin_ff[k];
         tb_sel[k] = cmd.close ? tf_ff[k] : tn_ff[k];
      end
   end

   assign ai    = clip3(cmd.cnt[1:0]);
   assign pi    = clip3(cmd.cnt[1:0] - 2'd1);
   assign dk    = clip3(cmd.cnt[5:4]);
   assign dstep = cmd.cnt[3:0];

   assign stat.edge_ok = (|{pu_ff[0], pu_ff[1], pu_ff[2]})
                       & (|{tp_ff[0], tp_ff[1], tp_ff[2]})
                       & (|{tb_sel[0], tb_sel[1], tb_sel[2]});

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         spip_pkg::OP_SQ: begin
            mul_a = spip_pkg::MUL_A_W'(w_sel[ai]);
            mul_b = spip_pkg::MUL_B_W'(w_sel[ai]);
         end
         spip_pkg::OP_DOT: begin
            mul_a = spip_pkg::MUL_A_W'(u_ff[ai]);
            mul_b = spip_pkg::MUL_B_W'(pu_ff[ai]);
         end
         spip_pkg::OP_PROJ: begin
            mul_a = spip_pkg::MUL_A_W'(acc_ff);
            mul_b = spip_pkg::MUL_B_W'(pu_ff[ai]);
         end
         spip_pkg::OP_CROSS: begin
            case (cmd.cnt)
               6'd0: begin
                  mul_a = spip_pkg::MUL_A_W'(tp_ff[1]);
                  mul_b = spip_pkg::MUL_B_W'(tb_sel[2]);
               end
               6'd1: begin
                  mul_a = spip_pkg::MUL_A_W'(tp_ff[2]);
                  mul_b = spip_pkg::MUL_B_W'(tb_sel[1]);
               end
               6'd2: begin
                  mul_a = spip_pkg::MUL_A_W'(tp_ff[2]);
                  mul_b = spip_pkg::MUL_B_W'(tb_sel[0]);
               end
               6'd3: begin
                  mul_a = spip_pkg::MUL_A_W'(tp_ff[0]);
                  mul_b = spip_pkg::MUL_B_W'(tb_sel[2]);
               end
               6'd4: begin
                  mul_a = spip_pkg::MUL_A_W'(tp_ff[0]);
                  mul_b = spip_pkg::MUL_B_W'(tb_sel[1]);
               end
               6'd5: begin
                  mul_a = spip_pkg::MUL_A_W'(tp_ff[1]);
                  mul_b = spip_pkg::MUL_B_W'(tb_sel[0]);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         spip_pkg::OP_SDOT: begin
            mul_a = spip_pkg::MUL_A_W'(c_ff[ai]);
            mul_b = spip_pkg::MUL_B_W'(pu_ff[ai]);
         end
         spip_pkg::OP_CDOT: begin
            mul_a = spip_pkg::MUL_A_W'(tp_ff[ai]);
            mul_b = spip_pkg::MUL_B_W'(tb_sel[ai]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = W'(mul_p);
   assign acc_sum = acc_ff + prod_ff;

   // square root digit, divider bit, projection and CORDIC step terms
   assign rem_sh    = {rem_ff, s_ff[spip_pkg::SUM_W-1 -: 2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign mag       = w_sel[dk][C-1] ? C'(-w_sel[dk]) : C'(w_sel[dk]);
   assign r_base    = (dstep == 4'd0) ? {1'b0, mag} : {r_ff[C-1:0], 1'b0};
   assign ge        = r_base >= {1'b0, root_ff};
   assign q_new     = {q_ff[spip_pkg::QUO_W-2:0], ge};
   assign proj_wide = W'(u_ff[pi]) - (prod_ff >>> 30);
   assign dx        = y_ff >>> cmd.cnt[4:0];
   assign dy        = x_ff >>> cmd.cnt[4:0];
   assign t_ang     = spip_pkg::ANG_W'(spip_pkg::atan_entry(cmd.cnt[4:0]));

   always_comb begin
      qp_in    = qp_ff;
      vin_in   = vin_ff;
      u_in     = u_ff;
      pu_in    = pu_ff;
      tp_in    = tp_ff;
      tf_in    = tf_ff;
      tn_in    = tn_ff;
      c_in     = c_ff;
      acc_in   = acc_ff;
      sin_in   = sin_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sum_in   = sum_ff;
      zflag_in = zflag_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      rsp_in   = rsp_ff;
      case (cmd.op)
         spip_pkg::OP_LOAD: begin
            vin_in[0] = req_data.vertex_x;
            vin_in[1] = req_data.vertex_y;
            vin_in[2] = req_data.vertex_z;
            if (cmd.first) begin
               qp_in[0] = req_data.point_x;
               qp_in[1] = req_data.point_y;
               qp_in[2] = req_data.point_z;
               sum_in   = '0;
            end
         end
         spip_pkg::OP_SQ, spip_pkg::OP_DOT, spip_pkg::OP_SDOT, spip_pkg::OP_CDOT: begin
            acc_in = (cmd.cnt == '0) ? '0 : acc_sum;
            if (cmd.cnt == spip_pkg::CNT_W'(spip_pkg::SQ_LAST)) begin
               // sum of squares feeds the root; only the cross.p sum is the sine
               if (cmd.op == spip_pkg::OP_SQ) begin
                  s_in    = spip_pkg::SUM_W'(acc_sum);
                  rem_in  = '0;
                  root_in = '0;
               end
               if (cmd.op == spip_pkg::OP_SDOT) sin_in = acc_sum >>> 15;
            end
         end
         spip_pkg::OP_SQRT: begin
            s_in = s_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = spip_pkg::REM_W'(rem_sh - trial);
               root_in = {root_ff[spip_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = spip_pkg::REM_W'(rem_sh);
               root_in = {root_ff[spip_pkg::ROOT_W-2:0], 1'b0};
            end
         end
         spip_pkg::OP_DIV: begin
            r_in = ge ? (r_base - {1'b0, root_ff}) : r_base;
            q_in = q_new;
            if (dstep == 4'd15) begin
               if (root_ff == '0)
                  u_in[dk] = '0;
               else if (w_sel[dk][C-1])
                  u_in[dk] = -UW'(q_new);
               else
                  u_in[dk] = UW'(q_new);
            end
         end
         spip_pkg::OP_SETP: pu_in = u_ff;
         spip_pkg::OP_PROJ: begin
            if (cmd.cnt != '0) tn_in[pi] = PW'(proj_wide);
         end
         spip_pkg::OP_TFIRST: begin
            tf_in = tn_ff;
            tp_in = tn_ff;
         end
         spip_pkg::OP_CROSS: begin
            if (cmd.cnt[0]) acc_in = prod_ff;
            else if (cmd.cnt != '0)
               c_in[clip3(cmd.cnt[2:1] - 2'd1)] = spip_pkg::CROSS_W'(acc_ff - prod_ff);
         end
         spip_pkg::OP_CINIT: begin
            if (sin_ff == '0) begin
               zflag_in = 1'b1;
               z_in     = acc_ff[W-1] ? spip_pkg::ANG_W'(32768) : '0;
            end else begin
               zflag_in = 1'b0;
               if (acc_ff[W-1]) begin
                  if (!sin_ff[W-1]) begin
                     x_in = sin_ff;
                     y_in = -acc_ff;
                     z_in = spip_pkg::ANG_W'(16384);
                  end else begin
                     x_in = -sin_ff;
                     y_in = acc_ff;
                     z_in = -spip_pkg::ANG_W'(16384);
                  end
               end else begin
                  x_in = acc_ff;
                  y_in = sin_ff;
                  z_in = '0;
               end
            end
         end
         spip_pkg::OP_CITER: begin
            if (!zflag_ff) begin
               if (y_ff > 0) begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + t_ang;
               end else begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - t_ang;
               end
            end
         end
         spip_pkg::OP_ACC: begin
            if (cmd.add) sum_in = sum_ff + z_ff;
            if (!cmd.close) tp_in = tn_ff;
         end
         spip_pkg::OP_EMIT: begin
            if (cmd.too_few) begin
               rsp_in.inside_res       = 1'b0;
               rsp_in.winding_sum      = '0;
               rsp_in.too_few_vertices = 1'b1;
            end else begin
               rsp_in.inside_res       = (sum_ff > 32768) || (sum_ff < -32768);
               rsp_in.winding_sum      = sum_ff;
               rsp_in.too_few_vertices = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      qp_ff    <= qp_in;
      vin_ff   <= vin_in;
      u_ff     <= u_in;
      pu_ff    <= pu_in;
      tp_ff    <= tp_in;
      tf_ff    <= tf_in;
      tn_ff    <= tn_in;
      c_ff     <= c_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      sin_ff   <= sin_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      sum_ff   <= sum_in;
      zflag_ff <= zflag_in;
      s_ff     <= s_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: design/spip_ctrl.sv
// Controller: sequences the datapath per transaction and owns handshakes.
`default_nettype none
module spip_ctrl #(
   parameter int CORDIC_STEPS = spip_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_first,
   input  wire logic               req_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire spip_pkg::stat_type stat,
   output spip_pkg::cmd_type       cmd
);

   localparam int CW = spip_pkg::CNT_W;

   spip_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    count_ff, count_in;
   logic src_q_ff, src_q_in, close_ff, close_in, add_ff, add_in;
   logic first_ff, first_in, last_ff, last_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, emit_fire;
   logic [CW-1:0] cnt_inc;
   logic [1:0]    count_next;

   assign accept     = (state_ff == spip_pkg::S_IDLE) && req_valid;
   assign emit_fire  = (state_ff == spip_pkg::S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign cnt_inc    = cnt_ff + 1'b1;
   assign count_next = (count_ff == 2'd3) ? 2'd3 : count_ff + 2'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      count_in = count_ff;
      src_q_in = src_q_ff;
      close_in = close_ff;
      add_in   = add_ff;
      first_in = first_ff;
      last_in  = last_ff;
      case (state_ff)
         spip_pkg::S_IDLE: begin
            if (req_valid) begin
               first_in = req_first;
               last_in  = req_last;
               close_in = 1'b0;
               if (req_first) begin
                  count_in = 2'd1;
                  src_q_in = 1'b1;
                  state_in = spip_pkg::S_SQ;
               end else if (count_ff != 2'd0) begin
                  src_q_in = 1'b0;
                  state_in = spip_pkg::S_SQ;
               end
            end
         end
         spip_pkg::S_SQ: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::SQ_LAST)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_SQRT;
            end
         end
         spip_pkg::S_SQRT: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::ROOT_W - 1)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_DIV;
            end
         end
         spip_pkg::S_DIV: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::DIV_LAST)) begin
               cnt_in   = '0;
               state_in = src_q_ff ? spip_pkg::S_SETP : spip_pkg::S_DOT;
            end
         end
         spip_pkg::S_SETP: begin
            src_q_in = 1'b0;
            state_in = spip_pkg::S_SQ;
         end
         spip_pkg::S_DOT: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::SQ_LAST)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_PROJ;
            end
         end
         spip_pkg::S_PROJ: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::SQ_LAST)) begin
               cnt_in   = '0;
               state_in = first_ff ? spip_pkg::S_TFIRST : spip_pkg::S_EDGE;
            end
         end
         spip_pkg::S_TFIRST: state_in = last_ff ? spip_pkg::S_EMIT : spip_pkg::S_IDLE;
         spip_pkg::S_EDGE: begin
            add_in   = stat.edge_ok;
            state_in = stat.edge_ok ? spip_pkg::S_CROSS : spip_pkg::S_ACC;
         end
         spip_pkg::S_CROSS: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::CROSS_LAST)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_SDOT;
            end
         end
         spip_pkg::S_SDOT: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::SQ_LAST)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_CDOT;
            end
         end
         spip_pkg::S_CDOT: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(spip_pkg::SQ_LAST)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_CINIT;
            end
         end
         spip_pkg::S_CINIT: state_in = spip_pkg::S_CITER;
         spip_pkg::S_CITER: begin
            cnt_in = cnt_inc;
            if (cnt_ff == CW'(CORDIC_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = spip_pkg::S_ACC;
            end
         end
         spip_pkg::S_ACC: begin
            if (close_ff) begin
               state_in = spip_pkg::S_EMIT;
            end else begin
               count_in = count_next;
               if (!last_ff)
                  state_in = spip_pkg::S_IDLE;
               else if (count_next != 2'd3)
                  state_in = spip_pkg::S_EMIT;
               else begin
                  close_in = 1'b1;
                  state_in = spip_pkg::S_EDGE;
               end
            end
         end
         spip_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               count_in = 2'd0;
               state_in = spip_pkg::S_IDLE;
            end
         end
         default: state_in = spip_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid_in = emit_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // outputs
   always_comb begin
      cmd.op      = spip_pkg::OP_NONE;
      cmd.cnt     = cnt_ff;
      cmd.src_q   = src_q_ff;
      cmd.first   = first_ff;
      cmd.close   = close_ff;
      cmd.add     = add_ff;
      cmd.too_few = count_ff != 2'd3;
      case (state_ff)
         spip_pkg::S_IDLE: begin
            if (accept) begin
               cmd.op    = spip_pkg::OP_LOAD;
               cmd.first = req_first;
            end
         end
         spip_pkg::S_SQ:     cmd.op = spip_pkg::OP_SQ;
         spip_pkg::S_SQRT:   cmd.op = spip_pkg::OP_SQRT;
         spip_pkg::S_DIV:    cmd.op = spip_pkg::OP_DIV;
         spip_pkg::S_SETP:   cmd.op = spip_pkg::OP_SETP;
         spip_pkg::S_DOT:    cmd.op = spip_pkg::OP_DOT;
         spip_pkg::S_PROJ:   cmd.op = spip_pkg::OP_PROJ;
         spip_pkg::S_TFIRST: cmd.op = spip_pkg::OP_TFIRST;
         spip_pkg::S_CROSS:  cmd.op = spip_pkg::OP_CROSS;
         spip_pkg::S_SDOT:   cmd.op = spip_pkg::OP_SDOT;
         spip_pkg::S_CDOT:   cmd.op = spip_pkg::OP_CDOT;
         spip_pkg::S_CINIT:  cmd.op = spip_pkg::OP_CINIT;
         spip_pkg::S_CITER:  cmd.op = spip_pkg::OP_CITER;
         spip_pkg::S_ACC:    cmd.op = spip_pkg::OP_ACC;
         spip_pkg::S_EMIT:   cmd.op = emit_fire ? spip_pkg::OP_EMIT : spip_pkg::OP_NONE;
         default:            cmd.op = spip_pkg::OP_NONE;
      endcase
   end

   assign req_ready = state_ff == spip_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spip_pkg::S_IDLE;
         cnt_ff       <= '0;
         count_ff     <= 2'd0;
         src_q_ff     <= 1'b0;
         close_ff     <= 1'b0;
         add_ff       <= 1'b0;
         first_ff     <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         src_q_ff     <= src_q_in;
         close_ff     <= close_in;
         add_ff       <= add_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// File: sim/spip_checker.sv
// Transaction checker: predicts winding results and compares accepted responses.
`default_nettype none
module spip_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire spip_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire spip_pkg::rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending,
   output int                     result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spip_pkg::*;

   localparam int STEPS = CORDIC_STEPS_DEF;

   longint      bam_atan_tab [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                      41, 20, 10, 5, 3, 1, 1, 0};
   longint      query_pt [3];
   longint      first_pt [3];
   longint      prev_pt  [3];
   bit [31:0]   winding_acc;
   int unsigned open_count;
   rsp_type     winding_expect [$];

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void normalize(input longint c [3], output longint u [3]);
      longint unsigned s;
      longint          n;
      s = 0;
      for (int k = 0; k < 3; k++) s += longint'(c[k] * c[k]);
      n = longint'(int_sqrt(s));
      for (int k = 0; k < 3; k++) u[k] = (n == 0) ? 0 : (c[k] * 32768) / n;
   endfunction

   // projection onto the tangent plane at unit point p; 0 when degenerate
   function automatic bit tangent(input longint v [3], input longint p [3],
                                  output longint t [3]);
      longint u [3];
      longint d;
      normalize(v, u);
      d = u[0] * p[0] + u[1] * p[1] + u[2] * p[2];
      for (int k = 0; k < 3; k++) t[k] = u[k] - ((p[k] * d) >>> 30);
      return (t[0] != 0) || (t[1] != 0) || (t[2] != 0);
   endfunction

   function automatic longint bam_atan2(input longint y, input longint x);
      longint z, nx, dx, dy;
      z = 0;
      if (y == 0) return (x >= 0) ? 0 : 32768;
      if (x < 0) begin
         if (y > 0) begin
            nx = y; y = -x; x = nx; z = 16384;
         end else begin
            nx = -y; y = x; x = nx; z = -16384;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += bam_atan_tab[i];
         end else begin
            x -= dx; y += dy; z -= bam_atan_tab[i];
         end
      end
      return z;
   endfunction

   function automatic void add_edge(input longint va [3], input longint vb [3]);
      longint p [3], a [3], b [3], c [3];
      longint s, co, ang;
      normalize(query_pt, p);
      if (p[0] == 0 && p[1] == 0 && p[2] == 0) return;
      if (!tangent(va, p, a)) return;
      if (!tangent(vb, p, b)) return;
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      s    = (c[0] * p[0] + c[1] * p[1] + c[2] * p[2]) >>> 15;
      co   = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      ang  = bam_atan2(s, co);
      winding_acc = winding_acc + ang[31:0];
   endfunction

   task automatic predict_vertex(input req_type t);
      longint  v [3];
      rsp_type r;
      longint  mag;
      v[0] = longint'(t.vertex_x);
      v[1] = longint'(t.vertex_y);
      v[2] = longint'(t.vertex_z);
      if (t.first_vertex) begin
         query_pt[0] = longint'(t.point_x);
         query_pt[1] = longint'(t.point_y);
         query_pt[2] = longint'(t.point_z);
         first_pt    = v;
         prev_pt     = v;
         winding_acc = '0;
         open_count  = 1;
      end else begin
         if (open_count == 0) return;   // orphan vertex, ignored
         add_edge(prev_pt, v);
         prev_pt = v;
         if (open_count < 3) open_count++;
      end
      if (!t.last_vertex) return;
      if (open_count < 3) begin
         r.inside_res       = 1'b0;
         r.winding_sum      = '0;
         r.too_few_vertices = 1'b1;
      end else begin
         add_edge(prev_pt, first_pt);
         mag = longint'(signed'(winding_acc));
         if (mag < 0) mag = -mag;
         r.inside_res       = (mag > 32768);
         r.winding_sum      = winding_acc;
         r.too_few_vertices = 1'b0;
      end
      open_count = 0;
      winding_expect.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            query_pt[k] = 0; first_pt[k] = 0; prev_pt[k] = 0;
         end
         winding_acc = '0;
         open_count  = 0;
         fail_count   <= 0;
         result_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (winding_expect.size() == 0) begin
               $error("unexpected response transaction: winding_sum %0d",
                      rsp_data.winding_sum);
               fail_count <= fail_count + 1;
            end else begin
               e = winding_expect.pop_front();
               if (rsp_data !== e) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.inside_res !== e.inside_res)
                     $error("inside_res expected %0b actual %0b",
                            e.inside_res, rsp_data.inside_res);
                  if (rsp_data.winding_sum !== e.winding_sum)
                     $error("winding_sum expected %0d actual %0d",
                            e.winding_sum, rsp_data.winding_sum);
                  if (rsp_data.too_few_vertices !== e.too_few_vertices)
                     $error("too_few_vertices expected %0b actual %0b",
                            e.too_few_vertices, rsp_data.too_few_vertices);
               end
            end
         end
         if (req_valid && req_ready) predict_vertex(req_data);
      end
      pending <= winding_expect.size();
   end

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench top: stimulus, flow control and verdict for the point-in-polygon block.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import spip_pkg::*;

   // no-progress limit: covers the worst vertex plus stalls
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int RANDOM_ITEMS   = 680;
   localparam int QUIET_TAIL     = 60;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count, pending, result_count;
   bit idle_on       = 1'b0;
   int rsp_stall     = 0;
   int stall_cycles  = 0;
   int items_sent    = 0;
   int polygons_sent = 0;

   always #6 clock = ~clock;

   spherical_point_in_polygon u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   spip_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count)
   );

   // response side: random stall bursts while idling is enabled
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // One request transaction. Called just after a rising edge; returns just
   // after the edge that accepted it, with valid still high so a following
   // call can reuse that edge without a second assignment.
   task automatic send_vertex(input logic [15:0] px, py, pz, vx, vy, vz,
                              input bit first, last);
      req_type t;
      t.point_x = px; t.point_y = py; t.point_z = pz;
      t.vertex_x = vx; t.vertex_y = vy; t.vertex_z = vz;
      t.first_vertex = first;
      t.last_vertex  = last;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [15:0] rnd16();
      logic [31:0] r;
      r = $urandom;
      return r[15:0];
   endfunction

   function automatic logic [15:0] to_q15(input real r);
      int i;
      i = $rtoi(r);
      if (i > 32767) i = 32767;
      if (i < -32768) i = -32768;
      return i[15:0];
   endfunction

   // Polygon ringed around an axis. The point sits on or, with jitter, near that axis (or its
   // antipode when outside is wanted); axis picks x, y or z as the normal.
   task automatic ring_polygon(input int n, input int axis, input bit antipode,
                               input bit reverse, input real jitter);
      real         pi, ang, rad, h, c [3], q [3];
      logic [15:0] pv [3], vv [3];
      pi  = 3.14159265358979;
      h   = 14000.0 + $urandom_range(0, 12000);
      rad = 8000.0 + $urandom_range(0, 14000);
      q[0] = jitter * ($urandom_range(0, 2000) - 1000.0);
      q[1] = jitter * ($urandom_range(0, 2000) - 1000.0);
      q[2] = antipode ? -20000.0 : 20000.0;
      for (int k = 0; k < 3; k++) pv[(k + axis) % 3] = to_q15(q[k]);
      for (int i = 0; i < n; i++) begin
         ang = 2.0 * pi * i / n + jitter * ($urandom_range(0, 100) - 50.0) / 200.0;
         if (reverse) ang = -ang;
         c[0] = rad * $cos(ang);
         c[1] = rad * $sin(ang);
         c[2] = h;
         for (int k = 0; k < 3; k++) vv[(k + axis) % 3] = to_q15(c[k]);
         send_vertex(pv[0], pv[1], pv[2], vv[0], vv[1], vv[2], i == 0, i == n - 1);
      end
      polygons_sent++;
   endtask

   // fully random coordinates; last flag optional to leave a polygon open
   task automatic random_polygon(input int n, input bit close);
      logic [15:0] px, py, pz;
      px = rnd16(); py = rnd16(); pz = rnd16();
      for (int i = 0; i < n; i++)
         send_vertex(px, py, pz, rnd16(), rnd16(), rnd16(), i == 0,
                     close && (i == n - 1));
      polygons_sent++;
   endtask

   initial begin
      int kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // inside and outside rings, both orientations
      ring_polygon(4, 2, 1'b0, 1'b0, 0.0);
      ring_polygon(3, 0, 1'b1, 1'b1, 0.0);
      // full-scale extremes of every coordinate
      send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1, 0);
      send_vertex(16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000, 16'h7fff, 0, 0);
      send_vertex(16'h0, 16'h0, 16'h0, 16'h8000, 16'h8000, 16'h8000, 0, 1);
      // zero query point: every edge contributes nothing
      send_vertex(16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 16'h0, 1, 0);
      send_vertex(16'h0, 16'h0, 16'h0, 16'h0, 16'h4000, 16'h0, 0, 0);
      send_vertex(16'h0, 16'h0, 16'h0, 16'hc000, 16'hc000, 16'h0, 0, 1);
      // zero vertex and vertex parallel to the point: zero projections
      send_vertex(16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 1, 0);
      send_vertex(16'h0, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h2000, 0, 0);
      send_vertex(16'h0, 16'h0, 16'h7fff, 16'h4000, 16'h0, 16'h0, 0, 1);
      // zero sine with negative cosine: antipodal tangent directions
      send_vertex(16'h0, 16'h0, 16'h7fff, 16'h4000, 16'h0, 16'h0, 1, 0);
      send_vertex(16'h0, 16'h0, 16'h7fff, 16'hc000, 16'h0, 16'h0, 0, 0);
      send_vertex(16'h0, 16'h0, 16'h7fff, 16'h4000, 16'h0, 16'h0, 0, 1);
      // too few vertices: one and two
      send_vertex(16'h1234, 16'h0, 16'h0, 16'h0, 16'h5555, 16'h0, 1, 1);
      send_vertex(16'h1234, 16'h0, 16'h0, 16'h0, 16'h5555, 16'h0, 1, 0);
      send_vertex(16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 16'h5555, 0, 1);
      // orphans: plain and carrying last
      send_vertex(16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 0, 0);
      send_vertex(16'h1, 16'h2, 16'h3, 16'h4, 16'h5, 16'h6, 0, 1);
      // open polygon restarted by a new first vertex
      random_polygon(2, 1'b0);
      ring_polygon(3, 1, 1'b0, 1'b0, 0.0);

      // ---- random part ----
      idle_on = 1'b1;
      while (items_sent < RANDOM_ITEMS + 25) begin
         idle_on = (items_sent < RANDOM_ITEMS + 25 - QUIET_TAIL) &&
                   ($urandom_range(0, 3) != 0);
         // while items_sent is 300 to 309, drain everything before sending more
         if (items_sent >= 300 && items_sent < 310) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
         kind = $urandom_range(0, 99);
         if (kind < 65)
            ring_polygon($urandom_range(3, 8), $urandom_range(0, 2),
                         $urandom_range(0, 1), $urandom_range(0, 1), 1.0);
         else if (kind < 78)
            random_polygon($urandom_range(3, 6), 1'b1);
         else if (kind < 86)
            random_polygon($urandom_range(1, 2), 1'b1);
         else if (kind < 93)
            send_vertex(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(),
                        1'b0, $urandom_range(0, 1));
         else
            random_polygon($urandom_range(1, 4), 1'b0);
      end
      idle_on = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (pending != 0) $error("%0d expected results never arrived", pending);

      $display("Covered %0d vertex transactions in %0d polygons, %0d results checked.",
               items_sent, polygons_sent, result_count);
      $display("Mix: rings inside/outside, random, short, orphan and restarted polygons.");
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
design/spip_pkg.sv
design/spip_dp.sv
design/spip_ctrl.sv
design/spherical_point_in_polygon.sv
sim/spip_checker.sv
sim/tb_top.sv
